>>> rtl/bcsp_pkg.sv
package bcsp_pkg;

    // Input word kinds, carried on s_tuser.
    typedef enum logic [1:0] {
        CMD_RX_BYTE = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_START   = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    // Which control packet a run transmits, if any.
    typedef enum logic [2:0] {
        PKT_NONE     = 3'd0,
        PKT_SYNC     = 3'd1,
        PKT_CONF     = 3'd2,
        PKT_SYNC_RSP = 3'd3,
        PKT_CONF_RSP = 3'd4
    } pkt_kind_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_HDR_BAD = 3'd1,
        EV_IGNORED = 3'd2,
        EV_ACTED   = 3'd3,
        EV_TIMEOUT = 3'd4
    } frame_event_t;

    // Link state codes as seen on the result bus.
    localparam logic [2:0] LS_IDLE      = 3'd0;
    localparam logic [2:0] LS_SHY       = 3'd1;
    localparam logic [2:0] LS_CURIOUS   = 3'd2;
    localparam logic [2:0] LS_GARRULOUS = 3'd3;
    localparam logic [2:0] LS_FAILED    = 3'd4;

    localparam logic [7:0] SOF_BYTE    = 8'hC0;
    localparam logic [7:0] CHAN_BYTE_A = 8'h41;
    localparam logic [7:0] CHAN_BYTE_B = 8'h00;
    localparam logic [3:0] RETRY_RESET = 4'd10;
    localparam logic [3:0] LAST_IDX    = 4'd9;

    // Everything the result side needs to play out one run.
    typedef struct packed {
        pkt_kind_t    kind;
        frame_event_t ev;
        logic [2:0]   link_state;
    } run_desc_t;

    // Payload bytes five to eight of each control packet, byte five highest.
    function automatic logic [31:0] pkt_body(input pkt_kind_t kind);
        logic [31:0] body;
        case (kind)
            PKT_SYNC:     body = 32'hDADCEDED;
            PKT_CONF:     body = 32'hADEFACED;
            PKT_SYNC_RSP: body = 32'hACAFEFEE;
            PKT_CONF_RSP: body = 32'hDEADD0D0;
            default:      body = 32'h0000_0000;
        endcase
        return body;
    endfunction

    function automatic logic [7:0] pkt_byte(input pkt_kind_t kind, input logic [3:0] idx);
        logic [31:0] body;
        logic [7:0]  b;
        body = pkt_body(kind);
        case (idx)
            4'd0:    b = SOF_BYTE;
            4'd1:    b = 8'h00;
            4'd2:    b = CHAN_BYTE_A;
            4'd3:    b = CHAN_BYTE_B;
            4'd4:    b = 8'hBE;
            4'd5:    b = body[31:24];
            4'd6:    b = body[23:16];
            4'd7:    b = body[15:8];
            4'd8:    b = body[7:0];
            4'd9:    b = SOF_BYTE;
            default: b = 8'h00;
        endcase
        if (kind == PKT_NONE) begin
            b = 8'h00;
        end
        return b;
    endfunction

endpackage

>>> rtl/bcsp_link_ctrl.sv
module bcsp_link_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_data,
    input  logic                in_accept,
    input  bcsp_pkg::cmd_t      command,
    input  logic [7:0]          rx_byte,
    output bcsp_pkg::run_desc_t desc
);
    import bcsp_pkg::*;

    typedef enum logic [4:0] {
        LP_IDLE      = 5'b00001,
        LP_SHY       = 5'b00010,
        LP_CURIOUS   = 5'b00100,
        LP_GARRULOUS = 5'b01000,
        LP_FAILED    = 5'b10000
    } link_phase_t;

    link_phase_t link_phase_reg, link_phase_next;
    logic [3:0]  parse_reg, parse_next;
    logic [3:0]  sync_sends_reg, sync_sends_next;
    logic [3:0]  conf_sends_reg, conf_sends_next;
    logic [3:0]  retry_limit_reg;
    logic [7:0]  hdr0_reg, hdr1_reg, hdr2_reg;
    logic [7:0]  hdr0_next, hdr1_next, hdr2_next;
    logic [7:0]  pay0_reg, pay1_reg, pay2_reg;
    logic [7:0]  pay0_next, pay1_next, pay2_next;
    logic [3:0]  parse_eff;
    logic [7:0]  hdr_sum;
    logic [31:0] rx_payload;
    logic        link_open;
    pkt_kind_t   kind;
    frame_event_t ev;

    assign parse_eff  = (parse_reg > 4'd8) ? 4'd0 : parse_reg;
    assign hdr_sum    = hdr0_reg + hdr1_reg + hdr2_reg;
    assign rx_payload = {pay0_reg, pay1_reg, pay2_reg, rx_byte};
    assign link_open  = (link_phase_reg == LP_SHY) || (link_phase_reg == LP_CURIOUS);

    always_comb begin
        link_phase_next = link_phase_reg;
        parse_next      = parse_reg;
        sync_sends_next = sync_sends_reg;
        conf_sends_next = conf_sends_reg;
        hdr0_next = hdr0_reg;
        hdr1_next = hdr1_reg;
        hdr2_next = hdr2_reg;
        pay0_next = pay0_reg;
        pay1_next = pay1_reg;
        pay2_next = pay2_reg;
        kind = PKT_NONE;
        ev   = EV_NONE;
        case (command)
            CMD_RX_BYTE: begin
                if (link_open) begin
                    case (parse_eff)
                        4'd0: begin
                            parse_next = (rx_byte == SOF_BYTE) ? 4'd1 : 4'd0;
                        end
                        4'd1: begin
                            // Repeated flag bytes are skipped.
                            if (rx_byte != SOF_BYTE) begin
                                hdr0_next  = rx_byte;
                                parse_next = 4'd2;
                            end
                        end
                        4'd2: begin
                            hdr1_next  = rx_byte;
                            parse_next = 4'd3;
                        end
                        4'd3: begin
                            hdr2_next  = rx_byte;
                            parse_next = 4'd4;
                        end
                        4'd4: begin
                            if ((hdr_sum != ~rx_byte) || (hdr1_reg != CHAN_BYTE_A) ||
                                (hdr2_reg != CHAN_BYTE_B)) begin
                                parse_next = 4'd0;
                                ev         = EV_HDR_BAD;
                            end else begin
                                parse_next = 4'd5;
                            end
                        end
                        4'd5: begin
                            pay0_next  = rx_byte;
                            parse_next = 4'd6;
                        end
                        4'd6: begin
                            pay1_next  = rx_byte;
                            parse_next = 4'd7;
                        end
                        4'd7: begin
                            pay2_next  = rx_byte;
                            parse_next = 4'd8;
                        end
                        4'd8: begin
                            parse_next = 4'd0;
                            ev         = EV_IGNORED;
                            if (rx_payload == pkt_body(PKT_SYNC)) begin
                                kind = PKT_SYNC_RSP;
                                ev   = EV_ACTED;
                            end else if (link_phase_reg == LP_SHY) begin
                                if (rx_payload == pkt_body(PKT_SYNC_RSP)) begin
                                    link_phase_next = LP_CURIOUS;
                                    conf_sends_next = 4'd0;
                                    ev              = EV_ACTED;
                                end
                            end else begin
                                if (rx_payload == pkt_body(PKT_CONF)) begin
                                    kind = PKT_CONF_RSP;
                                    ev   = EV_ACTED;
                                end else if (rx_payload == pkt_body(PKT_CONF_RSP)) begin
                                    link_phase_next = LP_GARRULOUS;
                                    ev              = EV_ACTED;
                                end
                            end
                        end
                        default: begin
                            parse_next = 4'd0;
                        end
                    endcase
                end
            end
            CMD_TICK: begin
                if (link_phase_reg == LP_SHY) begin
                    if (sync_sends_reg < retry_limit_reg) begin
                        sync_sends_next = sync_sends_reg + 4'd1;
                        kind            = PKT_SYNC;
                    end else begin
                        link_phase_next = LP_FAILED;
                        parse_next      = 4'd0;
                        ev              = EV_TIMEOUT;
                    end
                end else if (link_phase_reg == LP_CURIOUS) begin
                    if (conf_sends_reg < retry_limit_reg) begin
                        conf_sends_next = conf_sends_reg + 4'd1;
                        kind            = PKT_CONF;
                    end else begin
                        link_phase_next = LP_FAILED;
                        parse_next      = 4'd0;
                        ev              = EV_TIMEOUT;
                    end
                end
            end
            CMD_START: begin
                link_phase_next = LP_SHY;
                parse_next      = 4'd0;
                sync_sends_next = 4'd1;
                conf_sends_next = 4'd0;
                kind            = PKT_SYNC;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        desc.kind = kind;
        desc.ev   = ev;
        case (link_phase_next)
            LP_IDLE:      desc.link_state = LS_IDLE;
            LP_SHY:       desc.link_state = LS_SHY;
            LP_CURIOUS:   desc.link_state = LS_CURIOUS;
            LP_GARRULOUS: desc.link_state = LS_GARRULOUS;
            LP_FAILED:    desc.link_state = LS_FAILED;
            default:      desc.link_state = LS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_phase_reg  <= LP_IDLE;
            parse_reg       <= 4'd0;
            sync_sends_reg  <= 4'd0;
            conf_sends_reg  <= 4'd0;
            retry_limit_reg <= RETRY_RESET;
        end else begin
            if (cfg_we) begin
                retry_limit_reg <= cfg_data;
            end
            if (in_accept) begin
                link_phase_reg <= link_phase_next;
                parse_reg      <= parse_next;
                sync_sends_reg <= sync_sends_next;
                conf_sends_reg <= conf_sends_next;
            end
        end
    end

    // Frame stores are always written before they are read.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            hdr0_reg <= hdr0_next;
            hdr1_reg <= hdr1_next;
            hdr2_reg <= hdr2_next;
            pay0_reg <= pay0_next;
            pay1_reg <= pay1_next;
            pay2_reg <= pay2_next;
        end
    end

endmodule

>>> rtl/bcsp_link_establishment.sv
// Link-establishment engine for a three-wire serial host link. Each input word carries a
// kind on s_tuser (received byte, one-second tick, start) and, for a received byte, the
// byte on s_tdata. A start, or a tick in shy or curious under the retry limit, sends a
// 10-byte sync or conf packet; received bytes go through a frame parser that answers
// sync and conf payloads with response packets and walks the link from shy through
// curious to garrulous, or to failed once retry_limit packets of one kind have been sent
// without progress. Every input word produces a run of either ten result words (one
// packet, tlast on the tenth) or a single word with the transmit flag low; link state and
// frame event repeat on every word of a run. The state update for an input word is done
// in the cycle it is accepted, so input words are taken one per clock while the result
// side keeps up. Results pass through the pending and current descriptor registers, and
// the emitter, giving one word per clock while m_tready is high, sets the sustained rate.
// One descriptor waits behind the run in progress, so a new input word can be accepted
// while the last word of the current run is still waiting to be taken.
module bcsp_link_establishment (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write: retry_limit.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tx_byte, [10:8] link_state, [13:11] frame_event
    output logic        m_tuser,   // [0] tx_valid
    output logic        m_tlast    // last_of_run
);
    import bcsp_pkg::*;

    logic      in_accept;
    run_desc_t desc;

    // Descriptor waiting behind the run in progress.
    logic      pend_valid_reg, pend_valid_next;
    run_desc_t pend_desc_reg;

    // Run being played out on the result bus.
    logic      cur_valid_reg, cur_valid_next;
    run_desc_t cur_desc_reg;
    logic [3:0] idx_reg, idx_next;

    logic      cur_free;
    logic      cur_load;
    logic      run_done;
    logic [7:0] tx_byte;

    // The register can always be taken.
    assign cfg_ready = 1'b1;

    assign in_accept = s_tvalid && s_tready;

    bcsp_link_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .command   (cmd_t'(s_tuser)),
        .rx_byte   (s_tdata),
        .desc      (desc)
    );

    // A run ends when its last word is taken; the waiting descriptor then moves up, and
    // its slot is free for a new input word in that same cycle.
    assign run_done = cur_valid_reg && m_tready && m_tlast;
    assign cur_free = !cur_valid_reg || run_done;
    assign cur_load = pend_valid_reg && cur_free;
    assign s_tready = !pend_valid_reg || cur_load;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (cur_load) begin
            pend_valid_next = 1'b0;
        end
        if (in_accept) begin
            pend_valid_next = 1'b1;
        end

        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (cur_load) begin
            cur_valid_next = 1'b1;
            idx_next       = 4'd0;
        end else if (run_done) begin
            cur_valid_next = 1'b0;
        end else if (cur_valid_reg && m_tready) begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            cur_valid_reg  <= 1'b0;
            idx_reg        <= 4'd0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            cur_valid_reg  <= cur_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            pend_desc_reg <= desc;
        end
        if (cur_load) begin
            cur_desc_reg <= pend_desc_reg;
        end
    end

    // Packet bytes come from the constant packet table; a run without a packet shows zero.
    assign tx_byte  = pkt_byte(cur_desc_reg.kind, idx_reg);
    assign m_tvalid = cur_valid_reg;
    assign m_tuser  = (cur_desc_reg.kind != PKT_NONE);
    assign m_tlast  = (cur_desc_reg.kind == PKT_NONE) || (idx_reg == LAST_IDX);
    assign m_tdata  = {2'b00, cur_desc_reg.ev, cur_desc_reg.link_state, tx_byte};

endmodule

>>> rtl/bcsp_link_checker.sv
module bcsp_link_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A word without a packet byte is always a run of its own.
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("empty result word without tlast");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[7:0] == 8'h00))
        else $error("empty result word carries a byte");

    // A packet is sent without gaps once it has started.
    a_packet_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser && !m_tlast |=> m_tvalid && m_tuser)
        else $error("packet interrupted");

    // Every packet closes with the frame flag.
    a_packet_ends_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && m_tlast |-> (m_tdata[7:0] == 8'hC0))
        else $error("packet does not end with the frame flag");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result word changed");

endmodule

bind bcsp_link_establishment bcsp_link_checker u_bcsp_link_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> test/tb_bcsp_link_establishment.sv
import bcsp_pkg::*;

// One expected result word, field by field.
typedef struct {
    logic         tx_valid;
    logic [7:0]   tx_byte;
    logic         is_last;
    logic [2:0]   state;
    frame_event_t ev;
} tx_word_t;

// Ways in which a generated frame may be spoilt.
typedef enum int {
    FLAW_NONE,
    FLAW_SUM,
    FLAW_CHAN_A,
    FLAW_CHAN_B,
    FLAW_CUT
} flaw_t;

class link_scoreboard;
    logic [3:0]  retry_max;
    logic [2:0]  link_st;
    int unsigned parse_ph;
    logic [7:0]  hdr [3];
    logic [7:0]  pay [3];
    logic [3:0]  sync_cnt;
    logic [3:0]  conf_cnt;
    tx_word_t    expected_q[$];
    int unsigned fail_count;

    function new();
        retry_max  = RETRY_RESET;
        link_st    = LS_IDLE;
        parse_ph   = 0;
        sync_cnt   = 4'd0;
        conf_cnt   = 4'd0;
        fail_count = 0;
        foreach (hdr[i]) hdr[i] = 8'h00;
        foreach (pay[i]) pay[i] = 8'h00;
    endfunction

    function void set_retry(logic [3:0] v);
        retry_max = v;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    // Bytes five to eight of each control packet, byte five in the top bits.
    function logic [31:0] frame_body(pkt_kind_t kind);
        case (kind)
            PKT_SYNC:     return 32'hDADCEDED;
            PKT_CONF:     return 32'hADEFACED;
            PKT_SYNC_RSP: return 32'hACAFEFEE;
            PKT_CONF_RSP: return 32'hDEADD0D0;
            default:      return 32'h0;
        endcase
    endfunction

    function logic [7:0] packet_byte(pkt_kind_t kind, int k);
        logic [31:0] body;
        logic [7:0]  b;
        body = frame_body(kind);
        case (k)
            0, 9:    b = SOF_BYTE;
            1:       b = 8'h00;
            2:       b = CHAN_BYTE_A;
            3:       b = CHAN_BYTE_B;
            4:       b = 8'hBE;
            default: b = body[8*(8-k) +: 8];
        endcase
        return b;
    endfunction

    function void push_packet(pkt_kind_t kind, frame_event_t ev);
        tx_word_t w;
        for (int k = 0; k < 10; k++) begin
            w.tx_valid = 1'b1;
            w.tx_byte  = packet_byte(kind, k);
            w.is_last  = (k == 9);
            w.state    = link_st;
            w.ev       = ev;
            expected_q.push_back(w);
        end
    endfunction

    function void push_empty(frame_event_t ev);
        tx_word_t w;
        w.tx_valid = 1'b0;
        w.tx_byte  = 8'h00;
        w.is_last  = 1'b1;
        w.state    = link_st;
        w.ev       = ev;
        expected_q.push_back(w);
    endfunction

    function void finish_frame(logic [31:0] body);
        if (body == frame_body(PKT_SYNC)) begin
            push_packet(PKT_SYNC_RSP, EV_ACTED);
        end else if (link_st == LS_SHY) begin
            if (body == frame_body(PKT_SYNC_RSP)) begin
                link_st  = LS_CURIOUS;
                conf_cnt = 4'd0;
                push_empty(EV_ACTED);
            end else begin
                push_empty(EV_IGNORED);
            end
        end else if (body == frame_body(PKT_CONF)) begin
            push_packet(PKT_CONF_RSP, EV_ACTED);
        end else if (body == frame_body(PKT_CONF_RSP)) begin
            link_st = LS_GARRULOUS;
            push_empty(EV_ACTED);
        end else begin
            push_empty(EV_IGNORED);
        end
    endfunction

    function void take_byte(logic [7:0] b);
        logic [7:0] hsum;
        if (link_st != LS_SHY && link_st != LS_CURIOUS) begin
            push_empty(EV_NONE);
        end else if (parse_ph == 0) begin
            parse_ph = (b == SOF_BYTE) ? 1 : 0;
            push_empty(EV_NONE);
        end else if (parse_ph == 1) begin
            if (b != SOF_BYTE) begin
                hdr[0]   = b;
                parse_ph = 2;
            end
            push_empty(EV_NONE);
        end else if (parse_ph <= 3) begin
            hdr[parse_ph-1] = b;
            parse_ph++;
            push_empty(EV_NONE);
        end else if (parse_ph == 4) begin
            hsum = hdr[0] + hdr[1] + hdr[2];
            if (hsum != ~b || hdr[1] != CHAN_BYTE_A || hdr[2] != CHAN_BYTE_B) begin
                parse_ph = 0;
                push_empty(EV_HDR_BAD);
            end else begin
                parse_ph = 5;
                push_empty(EV_NONE);
            end
        end else if (parse_ph <= 7) begin
            pay[parse_ph-5] = b;
            parse_ph++;
            push_empty(EV_NONE);
        end else begin
            parse_ph = 0;
            finish_frame({pay[0], pay[1], pay[2], b});
        end
    endfunction

    function void take_tick();
        if (link_st == LS_SHY && sync_cnt < retry_max) begin
            sync_cnt = sync_cnt + 4'd1;
            push_packet(PKT_SYNC, EV_NONE);
        end else if (link_st == LS_CURIOUS && conf_cnt < retry_max) begin
            conf_cnt = conf_cnt + 4'd1;
            push_packet(PKT_CONF, EV_NONE);
        end else if (link_st == LS_SHY || link_st == LS_CURIOUS) begin
            link_st  = LS_FAILED;
            parse_ph = 0;
            push_empty(EV_TIMEOUT);
        end else begin
            push_empty(EV_NONE);
        end
    endfunction

    function void note_word(cmd_t c, logic [7:0] b);
        case (c)
            CMD_RX_BYTE: take_byte(b);
            CMD_TICK:    take_tick();
            CMD_START: begin
                link_st  = LS_SHY;
                parse_ph = 0;
                sync_cnt = 4'd1;
                conf_cnt = 4'd0;
                push_packet(PKT_SYNC, EV_NONE);
            end
            default:     push_empty(EV_NONE);
        endcase
    endfunction

    function void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("MISMATCH %s", msg);
    endfunction

    function void check_result(logic [15:0] data, logic flag, logic last);
        tx_word_t exp_w;
        if (expected_q.size() == 0) begin
            note_failure($sformatf("result word with nothing expected: data %h flag %0b",
                                   data, flag));
            return;
        end
        exp_w = expected_q.pop_front();
        if (flag !== exp_w.tx_valid || data[7:0] !== exp_w.tx_byte ||
            last !== exp_w.is_last || data[10:8] !== exp_w.state ||
            data[13:11] !== exp_w.ev) begin
            note_failure($sformatf(
                "exp valid %0b byte %h last %0b state %0d event %0d / got %0b %h %0b %0d %0d",
                exp_w.tx_valid, exp_w.tx_byte, exp_w.is_last, exp_w.state, exp_w.ev,
                flag, data[7:0], last, data[10:8], data[13:11]));
        end
    endfunction
endclass

module tb_bcsp_link_establishment;

    // A run stalls this long with no word moving on any channel before it is abandoned.
    localparam int QUIET_LIMIT = 2000;

    // A clean handshake as the host would see it: two sync bytes of framing (the second
    // one is skipped by the parser), a header whose checksum is the complement of 0x41,
    // a sync payload, then a fresh frame carrying a sync-response payload.
    localparam logic [7:0] HANDSHAKE_BYTES [19] = '{
        8'hC0, 8'hC0, 8'h00, 8'h41, 8'h00, 8'hBE, 8'hDA, 8'hDC, 8'hED, 8'hED,
        8'hC0, 8'h00, 8'h41, 8'h00, 8'hBE, 8'hAC, 8'hAF, 8'hEF, 8'hEE
    };

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data  = 4'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [7:0] rx_byte
    logic [1:0]  s_tuser   = 2'd0;    // [1:0] command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;             // [7:0] tx_byte, [10:8] link_state, [13:11] frame_event
    logic        m_tuser;             // [0] tx_valid
    logic        m_tlast;

    link_scoreboard sb;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned sent_words     = 0;
    int unsigned quiet_cycles   = 0;

    bcsp_link_establishment i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The receiver decides afresh every cycle whether it will take a word.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every result word is checked against the oldest prediction. Results pass through the
    // pending and current descriptor registers, so a prediction is always in place first.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // Watchdog: a long stretch in which no word moves on any channel means a hang.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Offers one word, after a random number of idle cycles, and waits for it to be taken.
    // The prediction is made here, at the very edge that accepts the word, so that the
    // stimulus generator always sees the link state that the block will have. Valid is left
    // high on return so that back-to-back words need no second assignment in one step.
    task automatic send_word(input cmd_t c, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(c, b);
        sent_words++;
    endtask

    // Holds the input back until every predicted result has been seen, then lets the
    // pipeline settle before anything is reconfigured.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_retry(input logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_retry(v);
    endtask

    // Builds one frame: one to three sync bytes, a header and a four-byte payload. A
    // payload kind of PKT_NONE gives a random payload. The flaw spoils the checksum or a
    // channel byte, or cuts the frame short part-way through.
    task automatic send_frame(input pkt_kind_t kind, input flaw_t flaw);
        logic [7:0]  fr [$];
        logic [7:0]  h0;
        logic [7:0]  ha;
        logic [7:0]  hb;
        logic [7:0]  chk;
        logic [31:0] body;
        int unsigned cut;
        repeat ($urandom_range(1, 3)) fr.push_back(SOF_BYTE);
        // A sync byte as the first header byte would be swallowed as more framing.
        h0 = 8'($urandom_range(0, 255));
        if (h0 == SOF_BYTE) h0 = 8'h00;
        ha = CHAN_BYTE_A;
        hb = CHAN_BYTE_B;
        if (flaw == FLAW_CHAN_A) ha = ha ^ 8'($urandom_range(1, 255));
        if (flaw == FLAW_CHAN_B) hb = hb ^ 8'($urandom_range(1, 255));
        chk = ~(h0 + ha + hb);
        if (flaw == FLAW_SUM) chk = chk ^ 8'($urandom_range(1, 255));
        body = (kind == PKT_NONE) ? $urandom() : sb.frame_body(kind);
        fr.push_back(h0);
        fr.push_back(ha);
        fr.push_back(hb);
        fr.push_back(chk);
        for (int i = 3; i >= 0; i--) fr.push_back(body[8*i +: 8]);
        cut = (flaw == FLAW_CUT) ? $urandom_range(1, fr.size() - 1) : fr.size();
        for (int i = 0; i < cut; i++) send_word(CMD_RX_BYTE, fr[i]);
    endtask

    // Mostly well-formed frames with random payload kinds, so that the link walks through
    // shy and curious to garrulous, mixed with ticks, restarts, spoilt frames and noise.
    // Once the link has settled or failed, a restart is very likely, which keeps it busy.
    task automatic run_random(input int unsigned target);
        int unsigned stop_at;
        int unsigned pick;
        logic        active;
        stop_at = sent_words + target;
        while (sent_words < stop_at) begin
            active = (sb.link_st == LS_SHY || sb.link_st == LS_CURIOUS);
            pick   = $urandom_range(99);
            if (!active && pick < 70) begin
                send_word(CMD_START, 8'($urandom_range(0, 255)));
            end else if (pick < 50) begin
                send_frame(pkt_kind_t'($urandom_range(0, 4)), FLAW_NONE);
            end else if (pick < 62) begin
                send_word(CMD_TICK, 8'($urandom_range(0, 255)));
            end else if (pick < 66) begin
                send_word(CMD_START, 8'($urandom_range(0, 255)));
            end else if (pick < 80) begin
                send_frame(pkt_kind_t'($urandom_range(0, 4)), flaw_t'($urandom_range(1, 4)));
            end else if (pick < 95) begin
                send_word(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
            end else begin
                send_word(CMD_UNUSED, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        logic [3:0] retry_plan [8];
        sb = new();
        // Zero fails a phase on its first tick; fifteen is the widest window.
        retry_plan = '{4'd0, 4'd15, 4'd1, 4'd7, 4'd2, 4'd15, 4'd3, 4'd0};
        retry_plan[3] = 4'($urandom_range(1, 14));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening: the unused command and a byte and a tick while idle, then a
        // start, a resend of sync, the full handshake into curious and the first conf.
        write_retry(RETRY_RESET);
        send_word(CMD_UNUSED, 8'hFF);
        send_word(CMD_RX_BYTE, 8'hFF);
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_START, 8'h00);
        send_word(CMD_TICK, 8'h00);
        foreach (HANDSHAKE_BYTES[i]) send_word(CMD_RX_BYTE, HANDSHAKE_BYTES[i]);
        send_word(CMD_TICK, 8'h00);

        // Random phases. Each one begins with the pipeline drained and a new retry limit,
        // and runs under one of four idling patterns on the two streams.
        for (int p = 0; p < 8; p++) begin
            settle();
            write_retry(retry_plan[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            run_random(52);
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        // Give any stray extra words time to show up before the verdict.
        repeat (20) @(posedge aclk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/bcsp_pkg.sv
rtl/bcsp_link_ctrl.sv
rtl/bcsp_link_establishment.sv
rtl/bcsp_link_checker.sv
test/tb_bcsp_link_establishment.sv
